/* hw/rtl/dokq_pkg.sv */
`timescale 1ns / 1ps

package dokq_pkg;

   localparam int REQ_KEY_W = 16;
   localparam int STATUS_W  = 3;
   localparam int LEN_W     = 5;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_DELETE = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      ST_INSERTED  = 3'd0,
      ST_DUPLICATE = 3'd1,
      ST_REMOVED   = 3'd2,
      ST_NOT_FOUND = 3'd3,
      ST_EMPTY     = 3'd4,
      ST_FULL      = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      ACT_NONE   = 2'd0,
      ACT_APPEND = 2'd1,
      ACT_REMOVE = 2'd2
   } action_type;

   // controller to datapath
   typedef struct packed {
      logic       load;
      logic       step;
      logic       shift;
      logic       latch;
      status_type status;
      action_type action;
      logic       commit;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic hit;
      logic scan_end;
      logic op_delete;
      logic empty;
      logic full;
      logic out_free;
   } stat_type;

endpackage

/* hw/rtl/dedup_ordered_key_queue.sv */
`timescale 1ns / 1ps
// A search reads one stored key per cycle and stops early when an insert meets a duplicate;
// the registered result is presented once the scan ends and the output is free.
// A delete that hits closes the gap in the same pass, so it takes no longer than a miss.
// One item is handled at a time, bounded by the single read port of the key store; the
// next beat is taken while the previous result waits.
// Reset: synchronous, active high; empties the queue, key store contents are not cleared.
module dedup_ordered_key_queue
   import dokq_pkg::*;
#(
   parameter int DEPTH     = 16,
   parameter int KEY_WIDTH = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_operation,
   input  logic [REQ_KEY_W-1:0] req_process_key,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [STATUS_W-1:0]  rsp_status,
   output logic [LEN_W-1:0]     rsp_queue_length
);

   cmd_type  cmd;
   stat_type stat;

   dokq_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .stat     (stat),
      .cmd      (cmd)
   );

   dokq_dp #(
      .DEPTH    (DEPTH),
      .KEY_WIDTH(KEY_WIDTH)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_operation   (req_operation),
      .req_process_key (req_process_key),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_queue_length(rsp_queue_length)
   );

`ifndef SYNTHESIS
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("second beat taken while an item is in progress");

   a_commit_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid)
      else $error("committed result not presented");

   a_empty_len: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == ST_EMPTY)) |-> (rsp_queue_length == '0))
      else $error("empty status with non-zero length");

   a_full_len: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == ST_FULL)) |-> (rsp_queue_length == LEN_W'(DEPTH)))
      else $error("full status with wrong length");
`endif

endmodule

/* hw/rtl/dokq_ram.sv */
`timescale 1ns / 1ps

module dokq_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/dokq_dp.sv */
`timescale 1ns / 1ps

module dokq_dp
   import dokq_pkg::*;
#(
   parameter int DEPTH     = 16,
   parameter int KEY_WIDTH = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cmd_type              cmd,
   output stat_type             stat,
   input  logic                 req_operation,
   input  logic [REQ_KEY_W-1:0] req_process_key,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [STATUS_W-1:0]  rsp_status,
   output logic [LEN_W-1:0]     rsp_queue_length
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int OW = (CW > LEN_W) ? CW : LEN_W;

   logic                 op_ff, op_in;
   logic [KEY_WIDTH-1:0] key_ff, key_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic [CW-1:0]        idx_ff, idx_in;
   logic                 pend_ff, pend_in;
   logic [AW-1:0]        wp_ff, wp_in;
   status_type           st_ff, st_in;
   action_type           act_ff, act_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [LEN_W-1:0]     rsp_len_ff, rsp_len_in;

   logic                 rd_en;
   logic [KEY_WIDTH-1:0] rd_data;
   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   logic [KEY_WIDTH-1:0] wr_data;
   logic                 hit;
   logic [OW-1:0]        len_wide;

   assign hit   = pend_ff && (rd_data == key_ff);
   assign rd_en = cmd.step && (idx_ff < cnt_ff);

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = wp_ff;
      wr_data = rd_data;
      if (cmd.commit && (act_ff == ACT_APPEND)) begin
         wr_en   = 1'b1;
         wr_addr = cnt_ff[AW-1:0];
         wr_data = key_ff;
      end else if (cmd.step && cmd.shift && pend_ff) begin
         wr_en = 1'b1;
      end
   end

   dokq_ram #(
      .WIDTH(KEY_WIDTH),
      .DEPTH(DEPTH)
   ) u_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(idx_ff[AW-1:0]),
      .rd_data(rd_data)
   );

   always_comb begin
      op_in   = op_ff;
      key_in  = key_ff;
      idx_in  = idx_ff;
      pend_in = pend_ff;
      wp_in   = wp_ff;
      cnt_in  = cnt_ff;
      st_in   = st_ff;
      act_in  = act_ff;

      if (cmd.load) begin
         op_in   = req_operation;
         key_in  = KEY_WIDTH'(req_process_key);
         idx_in  = '0;
         pend_in = 1'b0;
      end else if (cmd.step) begin
         pend_in = rd_en;
         if (rd_en) begin
            idx_in = idx_ff + CW'(1);
         end
         if (!cmd.shift && hit) begin
            wp_in = AW'(idx_ff - CW'(1));
         end else if (cmd.shift && pend_ff) begin
            wp_in = wp_ff + AW'(1);
         end
      end

      if (cmd.latch) begin
         st_in  = cmd.status;
         act_in = cmd.action;
      end

      if (cmd.commit) begin
         case (act_ff)
            ACT_APPEND: cnt_in = cnt_ff + CW'(1);
            ACT_REMOVE: cnt_in = cnt_ff - CW'(1);
            default:    cnt_in = cnt_ff;
         endcase
      end
   end

   assign len_wide = OW'(cnt_in);

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_len_in    = rsp_len_ff;
      if (cmd.commit) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = st_ff;
         rsp_len_in    = len_wide[LEN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      key_ff        <= key_in;
      idx_ff        <= idx_in;
      wp_ff         <= wp_in;
      st_ff         <= st_in;
      act_ff        <= act_in;
      rsp_status_ff <= rsp_status_in;
      rsp_len_ff    <= rsp_len_in;
   end

   assign stat.hit       = hit;
   assign stat.scan_end  = !pend_ff && (idx_ff == cnt_ff);
   assign stat.op_delete = (op_ff == OP_DELETE);
   assign stat.empty     = (cnt_ff == '0);
   assign stat.full      = (cnt_ff == CW'(DEPTH));
   assign stat.out_free  = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_queue_length = rsp_len_ff;

endmodule

/* hw/rtl/dokq_ctrl.sv */
`timescale 1ns / 1ps

module dokq_ctrl
   import dokq_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   input  stat_type stat,
   output cmd_type  cmd
);

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_SEARCH = 4'b0010,
      S_SHIFT  = 4'b0100,
      S_FINISH = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      cmd.status = ST_INSERTED;
      cmd.action = ACT_NONE;
      req_stall  = 1'b1;

      case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_SEARCH;
            end
         end
         S_SEARCH: begin
            cmd.step = 1'b1;
            if (stat.hit) begin
               if (stat.op_delete) begin
                  state_in = S_SHIFT;
               end else begin
                  cmd.latch  = 1'b1;
                  cmd.status = ST_DUPLICATE;
                  state_in   = S_FINISH;
               end
            end else if (stat.scan_end) begin
               cmd.latch = 1'b1;
               state_in  = S_FINISH;
               if (stat.op_delete) begin
                  cmd.status = stat.empty ? ST_EMPTY : ST_NOT_FOUND;
               end else if (stat.full) begin
                  cmd.status = ST_FULL;
               end else begin
                  cmd.status = ST_INSERTED;
                  cmd.action = ACT_APPEND;
               end
            end
         end
         S_SHIFT: begin
            cmd.step  = 1'b1;
            cmd.shift = 1'b1;
            if (stat.scan_end) begin
               cmd.latch  = 1'b1;
               cmd.status = ST_REMOVED;
               cmd.action = ACT_REMOVE;
               state_in   = S_FINISH;
            end
         end
         S_FINISH: begin
            if (stat.out_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
